// ===== hdl/osdc_pkg.sv =====
// ----------------------------------------------------------------------------
// osdc_pkg
// Shared types and constants for the overlay layer window clip pipeline.
// ----------------------------------------------------------------------------
package osdc_pkg;

    localparam int COORD_BITS   = 12;
    localparam int ADDR_BITS    = 32;
    localparam int ALIGN_H_BITS = 4;
    localparam int ALIGN_V_BITS = 1;
    localparam int PROD_BITS    = 25;
    localparam int MIN_HEIGHT   = 4;

    localparam logic [2:0] FMT_YUV420  = 3'd0;
    localparam logic [2:0] FMT_ARGB888 = 3'd1;
    localparam logic [2:0] FMT_Y_UV420 = 3'd4;
    localparam logic [2:0] FMT_LAST    = 3'd4;

    localparam logic CFG_SCREEN_W = 1'b0;
    localparam logic CFG_SCREEN_H = 1'b1;

    localparam logic [COORD_BITS-1:0] SCREEN_W_RST = 12'd800;
    localparam logic [COORD_BITS-1:0] SCREEN_H_RST = 12'd480;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic signed [COORD_BITS+2:0] t_span;

    typedef struct packed {
        t_coord width;
        t_coord height;
    } t_screen;

    typedef struct packed {
        logic        valid;
        logic [1:0]  layer;
        logic        ok;
        logic [1:0]  hw_format;
        logic        uv_il;
        t_coord      hpos;
        t_coord      vpos;
        t_coord      left;
        t_span       w;
        t_span       h;
        logic [12:0] mul_a;
        logic [11:0] mul_b;
        logic [1:0]  luma_sh;
        logic        uv_half;
        logic        u_en;
        logic        v_en;
        t_addr       yb;
        t_addr       ub;
        t_addr       vb;
    } t_clip_beat;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           layer;
        logic                 visible;
        logic [1:0]           hw_format;
        logic                 uv_il;
        t_coord               hpos;
        t_coord               vpos;
        t_coord               left;
        t_coord               w;
        t_coord               h;
        logic [PROD_BITS-1:0] prod;
        logic [1:0]           luma_sh;
        logic                 uv_half;
        logic                 u_en;
        logic                 v_en;
        t_addr                yb;
        t_addr                ub;
        t_addr                vb;
    } t_mul_beat;

    typedef struct packed {
        logic       valid;
        logic [1:0] layer;
        logic       visible;
        logic [1:0] hw_format;
        logic       uv_il;
        t_coord     screen_x;
        t_coord     screen_y;
        t_coord     skip_left;
        t_coord     shown_w;
        t_coord     shown_h;
        t_addr      luma;
        t_addr      chroma_u;
        t_addr      chroma_v;
    } t_result;

endpackage

// ===== hdl/osdc_clip.sv =====
// ----------------------------------------------------------------------------
// osdc_clip
// First stage: horizontal and vertical clip against the screen, operand
// select for the hidden-row address multiply.
// ----------------------------------------------------------------------------
module osdc_clip import osdc_pkg::*; #(
    parameter int NUM_LAYERS = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_screen            i_screen,
    input  logic [1:0]         i_layer_index,
    input  logic signed [12:0] i_pos_x,
    input  logic signed [12:0] i_pos_y,
    input  logic [11:0]        i_layer_width,
    input  logic [11:0]        i_layer_height,
    input  logic [2:0]         i_pixel_format,
    input  logic [31:0]        i_luma_base,
    input  logic [31:0]        i_chroma_u_base,
    input  logic [31:0]        i_chroma_v_base,
    input  logic [11:0]        i_source_stride,
    output t_clip_beat         o_beat
);

    logic        x_neg;
    logic        y_neg;
    logic [12:0] nx;
    logic [12:0] ny;
    t_coord      hpos;
    t_coord      vpos;
    logic [12:0] left;
    logic [12:0] hsum;
    logic [12:0] vsum;
    t_span       dw;
    t_span       hy;
    t_span       cw_s;
    t_span       ch_s;
    t_span       w;
    t_span       h;
    logic        yuv;
    t_clip_beat  n_beat;
    t_clip_beat  r_beat;

    assign x_neg = i_pos_x[12];
    assign y_neg = i_pos_y[12];
    assign nx    = ~i_pos_x + 13'd1;
    assign ny    = ~i_pos_y + 13'd1;
    assign yuv   = (i_pixel_format == FMT_YUV420) || (i_pixel_format == FMT_Y_UV420);

    assign hpos = x_neg ? '0 : {i_pos_x[11:ALIGN_H_BITS], ALIGN_H_BITS'(0)};
    assign vpos = y_neg ? '0 : {i_pos_y[11:ALIGN_V_BITS], ALIGN_V_BITS'(0)};
    assign left = x_neg ? {nx[12:ALIGN_H_BITS], ALIGN_H_BITS'(0)} : '0;

    assign hsum = {1'b0, hpos} + {1'b0, i_layer_width};
    assign vsum = {1'b0, vpos} + {1'b0, i_layer_height};
    assign cw_s = $signed({3'b0, i_screen.width});
    assign ch_s = $signed({3'b0, i_screen.height});
    assign dw   = $signed({3'b0, i_layer_width}) - $signed({2'b0, left});
    assign hy   = $signed({3'b0, i_layer_height}) - $signed({2'b0, ny});

    // horizontal clip
    always_comb begin
        w = $signed({3'b0, i_layer_width});
        if (!x_neg) begin
            if (hsum > {1'b0, i_screen.width}) begin
                w = cw_s - $signed({3'b0, hpos});
            end
        end else if (dw <= 0) begin
            w = dw;
        end else if (dw > cw_s) begin
            w = cw_s;
        end else begin
            w = dw;
        end
    end

    // vertical clip
    always_comb begin
        h = $signed({3'b0, i_layer_height});
        if (!y_neg) begin
            if (yuv && (i_layer_height > i_screen.height)) begin
                h = $signed({3'b0, i_layer_height}) - $signed({3'b0, i_pos_y[11:0]});
            end else if (vsum > {1'b0, i_screen.height}) begin
                h = ch_s - $signed({3'b0, vpos});
            end
        end else if (yuv) begin
            if (hy < ch_s) begin
                h = hy;
            end
        end else begin
            h = hy;
        end
    end

    always_comb begin
        n_beat           = '0;
        n_beat.valid     = i_valid;
        n_beat.layer     = i_layer_index;
        n_beat.ok        = (int'(i_layer_index) < NUM_LAYERS) && (i_pixel_format <= FMT_LAST);
        n_beat.hw_format = yuv ? 2'd0 : i_pixel_format[1:0];
        n_beat.uv_il     = (i_pixel_format == FMT_Y_UV420);
        n_beat.hpos      = hpos;
        n_beat.vpos      = vpos;
        n_beat.left      = left[COORD_BITS-1:0];
        n_beat.w         = w;
        n_beat.h         = h;
        n_beat.mul_a     = !y_neg ? '0 : (yuv ? {ny[12:1], 1'b0} : ny);
        n_beat.mul_b     = yuv ? i_source_stride : i_layer_width;
        n_beat.luma_sh   = yuv ? 2'd0 : ((i_pixel_format == FMT_ARGB888) ? 2'd2 : 2'd1);
        n_beat.uv_half   = (i_pixel_format == FMT_Y_UV420);
        n_beat.u_en      = yuv;
        n_beat.v_en      = (i_pixel_format == FMT_YUV420);
        n_beat.yb        = i_luma_base;
        n_beat.ub        = i_chroma_u_base;
        n_beat.vb        = i_chroma_v_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

// ===== hdl/osdc_mult.sv =====
// ----------------------------------------------------------------------------
// osdc_mult
// Second stage: hidden-row byte offset multiply and visibility decision.
// ----------------------------------------------------------------------------
module osdc_mult import osdc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_clip_beat i_beat,
    output t_mul_beat  o_beat
);

    t_mul_beat n_beat;
    t_mul_beat r_beat;

    always_comb begin
        n_beat           = '0;
        n_beat.valid     = i_beat.valid;
        n_beat.layer     = i_beat.layer;
        n_beat.visible   = i_beat.ok && (i_beat.w > 0) && (i_beat.h > MIN_HEIGHT);
        n_beat.hw_format = i_beat.hw_format;
        n_beat.uv_il     = i_beat.uv_il;
        n_beat.hpos      = i_beat.hpos;
        n_beat.vpos      = i_beat.vpos;
        n_beat.left      = i_beat.left;
        n_beat.w         = i_beat.w[COORD_BITS-1:0];
        n_beat.h         = i_beat.h[COORD_BITS-1:0];
        n_beat.prod      = PROD_BITS'(i_beat.mul_a * i_beat.mul_b);
        n_beat.luma_sh   = i_beat.luma_sh;
        n_beat.uv_half   = i_beat.uv_half;
        n_beat.u_en      = i_beat.u_en;
        n_beat.v_en      = i_beat.v_en;
        n_beat.yb        = i_beat.yb;
        n_beat.ub        = i_beat.ub;
        n_beat.vb        = i_beat.vb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

// ===== hdl/osdc_addr.sv =====
// ----------------------------------------------------------------------------
// osdc_addr
// Third stage: plane address adjust and result register, zeroed when the
// layer is hidden.
// ----------------------------------------------------------------------------
module osdc_addr import osdc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mul_beat i_beat,
    output t_result   o_res
);

    t_addr   prod32;
    t_addr   luma_off;
    t_addr   chroma_off;
    t_result n_res;
    t_result r_res;

    assign prod32     = ADDR_BITS'(i_beat.prod);
    assign luma_off   = prod32 << i_beat.luma_sh;
    assign chroma_off = i_beat.uv_half ? (prod32 >> 1) : (prod32 >> 2);

    always_comb begin
        n_res         = '0;
        n_res.valid   = i_beat.valid;
        n_res.layer   = i_beat.layer;
        n_res.visible = i_beat.visible;
        if (i_beat.visible) begin
            n_res.hw_format = i_beat.hw_format;
            n_res.uv_il     = i_beat.uv_il;
            n_res.screen_x  = i_beat.hpos;
            n_res.screen_y  = i_beat.vpos;
            n_res.skip_left = i_beat.left;
            n_res.shown_w   = i_beat.w;
            n_res.shown_h   = i_beat.h;
            n_res.luma      = i_beat.yb + luma_off;
            n_res.chroma_u  = i_beat.u_en ? (i_beat.ub + chroma_off) : '0;
            n_res.chroma_v  = i_beat.v_en ? (i_beat.vb + chroma_off) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== hdl/osd_layer_window_clip.sv =====
// one placement request per cycle enters the three-stage clip / multiply /
// address pipeline
// busy stays low: the pipeline never stalls and results need no acceptance
// synchronous active-low reset empties the pipeline and sets the screen
// size to 800 x 480
// ----------------------------------------------------------------------------
// osd_layer_window_clip
// Clips overlay layer placements against the screen and returns the layer
// register values: position, skip, clipped size and plane addresses.
// ----------------------------------------------------------------------------
module osd_layer_window_clip import osdc_pkg::*; #(
    parameter int NUM_LAYERS = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_layer_index,
    input  logic signed [12:0] i_pos_x,
    input  logic signed [12:0] i_pos_y,
    input  logic [11:0]        i_layer_width,
    input  logic [11:0]        i_layer_height,
    input  logic [2:0]         i_pixel_format,
    input  logic [31:0]        i_luma_base,
    input  logic [31:0]        i_chroma_u_base,
    input  logic [31:0]        i_chroma_v_base,
    input  logic [11:0]        i_source_stride,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    output logic               o_valid,
    output logic [1:0]         o_out_layer,
    output logic               o_visible,
    output logic [1:0]         o_hw_format,
    output logic               o_uv_interleaved,
    output logic [11:0]        o_screen_x,
    output logic [11:0]        o_screen_y,
    output logic [11:0]        o_skip_left,
    output logic [11:0]        o_shown_width,
    output logic [11:0]        o_shown_height,
    output logic [31:0]        o_luma_addr,
    output logic [31:0]        o_chroma_u_addr,
    output logic [31:0]        o_chroma_v_addr
);

    t_screen    r_screen;
    logic       accept;
    t_clip_beat clip_beat;
    t_mul_beat  mul_beat;
    t_result    res;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen.width  <= SCREEN_W_RST;
            r_screen.height <= SCREEN_H_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SCREEN_W: r_screen.width  <= i_cfg_data;
                CFG_SCREEN_H: r_screen.height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    osdc_clip #(
        .NUM_LAYERS(NUM_LAYERS)
    ) u_clip (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_screen       (r_screen),
        .i_layer_index  (i_layer_index),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_layer_width  (i_layer_width),
        .i_layer_height (i_layer_height),
        .i_pixel_format (i_pixel_format),
        .i_luma_base    (i_luma_base),
        .i_chroma_u_base(i_chroma_u_base),
        .i_chroma_v_base(i_chroma_v_base),
        .i_source_stride(i_source_stride),
        .o_beat         (clip_beat)
    );

    osdc_mult u_mult (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_beat (clip_beat),
        .o_beat (mul_beat)
    );

    osdc_addr u_addr (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_beat (mul_beat),
        .o_res  (res)
    );

    assign o_valid          = res.valid;
    assign o_out_layer      = res.layer;
    assign o_visible        = res.visible;
    assign o_hw_format      = res.hw_format;
    assign o_uv_interleaved = res.uv_il;
    assign o_screen_x       = res.screen_x;
    assign o_screen_y       = res.screen_y;
    assign o_skip_left      = res.skip_left;
    assign o_shown_width    = res.shown_w;
    assign o_shown_height   = res.shown_h;
    assign o_luma_addr      = res.luma;
    assign o_chroma_u_addr  = res.chroma_u;
    assign o_chroma_v_addr  = res.chroma_v;

    // every accepted beat leaves the clip, multiply and address registers as a result
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_valid)
        else $error("accepted beat did not come out after three cycles");

    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 3))
        else $error("result strobe without an accepted beat");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |-> o_shown_width == '0 && o_shown_height == '0
            && o_luma_addr == '0 && o_hw_format == '0)
        else $error("hidden layer result carries nonzero fields");

    a_visible_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_visible |-> o_shown_height > 12'(MIN_HEIGHT) && o_shown_width != '0)
        else $error("visible layer with too small a window");

    a_rgb_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_visible && o_hw_format != '0 |-> o_chroma_u_addr == '0
            && o_chroma_v_addr == '0)
        else $error("rgb layer with chroma address");

endmodule

// ===== bench/tb_osd_layer_window_clip.sv =====
// ----------------------------------------------------------------------------
// tb_osd_layer_window_clip
// Drives overlay placement requests into the clip pipeline and checks every
// returned register set against typed values or a behavioral clip computed in
// the bench, over several screen sizes, with random gaps on the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_osd_layer_window_clip;
    import osdc_pkg::*;

    localparam int N_LAYERS    = 3;
    localparam int PIPE_LAT    = 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 40;

    localparam logic [2:0] FMT_RGB565  = 3'd2;
    localparam logic [2:0] FMT_ARGB454 = 3'd3;
    localparam logic [2:0] FMT_BAD     = 3'd7;

    typedef struct {
        logic [1:0]         layer;
        logic signed [12:0] pos_x;
        logic signed [12:0] pos_y;
        logic [11:0]        width;
        logic [11:0]        height;
        logic [2:0]         fmt;
        logic [31:0]        luma;
        logic [31:0]        chroma_u;
        logic [31:0]        chroma_v;
        logic [11:0]        stride;
    } t_placement;

    typedef struct {
        t_placement pl;
        bit         typed;
        t_result    want;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_layer_index;
    logic signed [12:0] i_pos_x;
    logic signed [12:0] i_pos_y;
    logic [11:0]        i_layer_width;
    logic [11:0]        i_layer_height;
    logic [2:0]         i_pixel_format;
    logic [31:0]        i_luma_base;
    logic [31:0]        i_chroma_u_base;
    logic [31:0]        i_chroma_v_base;
    logic [11:0]        i_source_stride;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [11:0]        i_cfg_data;
    logic               o_valid;
    logic [1:0]         o_out_layer;
    logic               o_visible;
    logic [1:0]         o_hw_format;
    logic               o_uv_interleaved;
    logic [11:0]        o_screen_x;
    logic [11:0]        o_screen_y;
    logic [11:0]        o_skip_left;
    logic [11:0]        o_shown_width;
    logic [11:0]        o_shown_height;
    logic [31:0]        o_luma_addr;
    logic [31:0]        o_chroma_u_addr;
    logic [31:0]        o_chroma_v_addr;

    t_result    expected_layer_regs[$];
    t_dir_row   dir_table[$];
    t_coord     scr_w;
    t_coord     scr_h;
    int         n_errors;
    int         n_results;
    int         cycle_count;

    osd_layer_window_clip #(.NUM_LAYERS(N_LAYERS)) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_layer_index    (i_layer_index),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_layer_width    (i_layer_width),
        .i_layer_height   (i_layer_height),
        .i_pixel_format   (i_pixel_format),
        .i_luma_base      (i_luma_base),
        .i_chroma_u_base  (i_chroma_u_base),
        .i_chroma_v_base  (i_chroma_v_base),
        .i_source_stride  (i_source_stride),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_out_layer      (o_out_layer),
        .o_visible        (o_visible),
        .o_hw_format      (o_hw_format),
        .o_uv_interleaved (o_uv_interleaved),
        .o_screen_x       (o_screen_x),
        .o_screen_y       (o_screen_y),
        .o_skip_left      (o_skip_left),
        .o_shown_width    (o_shown_width),
        .o_shown_height   (o_shown_height),
        .o_luma_addr      (o_luma_addr),
        .o_chroma_u_addr  (o_chroma_u_addr),
        .o_chroma_v_addr  (o_chroma_v_addr)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_layer_regs.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_result clip_layer(input t_placement p, input t_coord sw,
                                           input t_coord sh);
        t_result         r;
        longint          x, y, lw, lh, cw, ch, hpos, vpos, left, w, h, rows;
        longint unsigned adv, adv_part;
        logic [31:0]     ya, ua, va;
        bit              yuv, ok;
        x    = longint'(p.pos_x);
        y    = longint'(p.pos_y);
        lw   = longint'(p.width);
        lh   = longint'(p.height);
        cw   = longint'(sw);
        ch   = longint'(sh);
        w    = lw;
        h    = lh;
        vpos = 0;
        ya   = p.luma;
        ua   = '0;
        va   = '0;
        yuv  = (p.fmt == FMT_YUV420) || (p.fmt == FMT_Y_UV420);
        ok   = (p.layer < N_LAYERS) && (p.fmt <= FMT_LAST);

        if (x >= 0) begin
            hpos = (x >> ALIGN_H_BITS) << ALIGN_H_BITS;
            left = 0;
            if (hpos + w > cw) w = cw - hpos;
        end else begin
            hpos = 0;
            left = ((-x) >> ALIGN_H_BITS) << ALIGN_H_BITS;
            if (lw <= left) w = lw - left;
            else if (lw - left < cw) w = lw - left;
            else if (w > cw) w = cw;
            else w = w - left;
        end

        if (yuv) begin
            if (y >= 0) begin
                vpos = (y >> ALIGN_V_BITS) << ALIGN_V_BITS;
                ua = p.chroma_u;
                if (p.fmt == FMT_YUV420) va = p.chroma_v;
                if (lh > ch) h = lh - y;
                else if (vpos + h > ch) h = ch - vpos;
            end else begin
                rows = ((-y) >> ALIGN_V_BITS) << ALIGN_V_BITS;
                adv  = longint'(rows) * longint'(p.stride);
                ya   = p.luma + adv[31:0];
                if (p.fmt == FMT_Y_UV420) begin
                    adv_part = adv >> 1;
                    ua = p.chroma_u + adv_part[31:0];
                end else begin
                    adv_part = adv >> 2;
                    ua = p.chroma_u + adv_part[31:0];
                    va = p.chroma_v + adv_part[31:0];
                end
                if (lh + y < ch) h = h + y;
            end
        end else begin
            if (y >= 0) begin
                vpos = (y >> ALIGN_V_BITS) << ALIGN_V_BITS;
                if (vpos + h > ch) h = ch - vpos;
            end else begin
                rows = -y;
                adv  = rows * lw * ((p.fmt == FMT_ARGB888) ? 4 : 2);
                ya   = p.luma + adv[31:0];
                h    = h + y;
            end
        end

        if (w <= 0 || h <= MIN_HEIGHT) ok = 1'b0;

        r       = '0;
        r.valid = 1'b1;
        r.layer = p.layer;
        if (ok) begin
            r.visible   = 1'b1;
            r.hw_format = yuv ? 2'd0 : p.fmt[1:0];
            r.uv_il     = (p.fmt == FMT_Y_UV420);
            r.screen_x  = hpos[11:0];
            r.screen_y  = vpos[11:0];
            r.skip_left = left[11:0];
            r.shown_w   = w[11:0];
            r.shown_h   = h[11:0];
            r.luma      = ya;
            r.chroma_u  = ua;
            r.chroma_v  = va;
        end
        return r;
    endfunction

    function automatic t_result hidden_regs(input logic [1:0] layer);
        t_result r;
        r       = '0;
        r.valid = 1'b1;
        r.layer = layer;
        return r;
    endfunction

    function automatic t_placement place(input logic [1:0] layer, input int x, input int y,
                                         input int w, input int h, input logic [2:0] fmt,
                                         input logic [31:0] yb, input logic [31:0] ub,
                                         input logic [31:0] vb, input int stride);
        t_placement p;
        p.layer    = layer;
        p.pos_x    = x[12:0];
        p.pos_y    = y[12:0];
        p.width    = w[11:0];
        p.height   = h[11:0];
        p.fmt      = fmt;
        p.luma     = yb;
        p.chroma_u = ub;
        p.chroma_v = vb;
        p.stride   = stride[11:0];
        return p;
    endfunction

    function automatic logic [11:0] pick_size(input int extent);
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 4095);
            1: v = $urandom_range(0, 8);
            2: v = $urandom_range(0, (extent + 32 > 4095) ? 4095 : extent + 32);
            default: v = $urandom_range(0, 512);
        endcase
        return v[11:0];
    endfunction

    function automatic logic signed [12:0] pick_pos(input int extent, input int size);
        int v;
        case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 8191);
            1: v = int'($urandom_range(0, 64)) - 32;
            2: v = int'($urandom_range(0, 64)) - 32 - size;
            3: v = int'($urandom_range(0, 64)) - 32 + extent - size;
            default: v = $urandom_range(0, extent);
        endcase
        return v[12:0];
    endfunction

    function automatic t_placement rand_placement(input int cw, input int ch);
        t_placement p;
        p.layer    = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        p.fmt      = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
        p.width    = pick_size(cw);
        p.height   = pick_size(ch);
        p.pos_x    = pick_pos(cw, int'(p.width));
        p.pos_y    = pick_pos(ch, int'(p.height));
        p.luma     = $urandom();
        p.chroma_u = $urandom();
        p.chroma_v = $urandom();
        p.stride   = ($urandom_range(0, 1) == 0) ? p.width : 12'($urandom_range(0, 4095));
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("result %0d: %s got 0x%0h want 0x%0h", n_results, what, got, want);
    endtask

    task automatic send_placement(input t_placement p, input int idle_pct,
                                  input t_result want);
        bit taken;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_layer_index   <= p.layer;
        i_pos_x         <= p.pos_x;
        i_pos_y         <= p.pos_y;
        i_layer_width   <= p.width;
        i_layer_height  <= p.height;
        i_pixel_format  <= p.fmt;
        i_luma_base     <= p.luma;
        i_chroma_u_base <= p.chroma_u;
        i_chroma_v_base <= p.chroma_v;
        i_source_stride <= p.stride;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        expected_layer_regs.push_back(want);
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        while (expected_layer_regs.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic write_screen(input t_coord w, input t_coord h);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SCREEN_W;
        i_cfg_data  <= w;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end
        scr_w = w;
        i_cfg_index <= CFG_SCREEN_H;
        i_cfg_data  <= h;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end
        scr_h = h;
        i_cfg_valid <= 1'b0;
    endtask

    // results are registered, so mid-cycle sampling sees a stable beat
    // between rising edges
    always @(negedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_valid) begin
            n_results++;
            got           = '0;
            got.layer     = o_out_layer;
            got.visible   = o_visible;
            got.hw_format = o_hw_format;
            got.uv_il     = o_uv_interleaved;
            got.screen_x  = o_screen_x;
            got.screen_y  = o_screen_y;
            got.skip_left = o_skip_left;
            got.shown_w   = o_shown_width;
            got.shown_h   = o_shown_height;
            got.luma      = o_luma_addr;
            got.chroma_u  = o_chroma_u_addr;
            got.chroma_v  = o_chroma_v_addr;
            if (expected_layer_regs.size() == 0) begin
                report_mismatch("beat with nothing pending, out_layer", got.layer, 0);
            end else begin
                want = expected_layer_regs.pop_front();
                if (got.layer !== want.layer)
                    report_mismatch("out_layer", got.layer, want.layer);
                if (got.visible !== want.visible)
                    report_mismatch("visible", got.visible, want.visible);
                if (got.hw_format !== want.hw_format)
                    report_mismatch("hw_format", got.hw_format, want.hw_format);
                if (got.uv_il !== want.uv_il)
                    report_mismatch("uv_interleaved", got.uv_il, want.uv_il);
                if (got.screen_x !== want.screen_x)
                    report_mismatch("screen_x", got.screen_x, want.screen_x);
                if (got.screen_y !== want.screen_y)
                    report_mismatch("screen_y", got.screen_y, want.screen_y);
                if (got.skip_left !== want.skip_left)
                    report_mismatch("skip_left", got.skip_left, want.skip_left);
                if (got.shown_w !== want.shown_w)
                    report_mismatch("shown_width", got.shown_w, want.shown_w);
                if (got.shown_h !== want.shown_h)
                    report_mismatch("shown_height", got.shown_h, want.shown_h);
                if (got.luma !== want.luma)
                    report_mismatch("luma_addr", got.luma, want.luma);
                if (got.chroma_u !== want.chroma_u)
                    report_mismatch("chroma_u_addr", got.chroma_u, want.chroma_u);
                if (got.chroma_v !== want.chroma_v)
                    report_mismatch("chroma_v_addr", got.chroma_v, want.chroma_v);
            end
        end
    end

    task automatic add_row(input t_placement p, input bit typed, input t_result want);
        t_dir_row row;
        row.pl    = p;
        row.typed = typed;
        row.want  = want;
        dir_table.push_back(row);
    endtask

    initial begin
        t_result    on_screen;
        t_placement p;
        int         phase_w[6];
        int         phase_h[6];
        int         phase_n[6];
        int         idle_pct;

        n_errors        = 0;
        n_results       = 0;
        cycle_count     = 0;
        scr_w           = SCREEN_W_RST;
        scr_h           = SCREEN_H_RST;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_layer_index   = '0;
        i_pos_x         = '0;
        i_pos_y         = '0;
        i_layer_width   = '0;
        i_layer_height  = '0;
        i_pixel_format  = '0;
        i_luma_base     = '0;
        i_chroma_u_base = '0;
        i_chroma_v_base = '0;
        i_source_stride = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_SCREEN_W;
        i_cfg_data      = '0;

        on_screen           = hidden_regs(2'd0);
        on_screen.visible   = 1'b1;
        on_screen.hw_format = 2'd1;
        on_screen.shown_w   = 12'd64;
        on_screen.shown_h   = 12'd32;
        on_screen.luma      = 32'h0000_1000;

        // screen at its reset size of 800 x 480
        add_row(place(0, 0, 0, 64, 32, FMT_ARGB888, 32'h1000, 32'h2000, 32'h3000, 64),
                1, on_screen);
        add_row(place(3, 0, 0, 64, 32, FMT_ARGB888, 32'h1000, 0, 0, 64), 1, hidden_regs(3));
        add_row(place(1, 0, 0, 64, 32, FMT_BAD, 32'h1000, 0, 0, 64), 1, hidden_regs(1));
        add_row(place(2, 0, 0, 64, 4, FMT_RGB565, 32'h1000, 0, 0, 64), 1, hidden_regs(2));
        add_row(place(0, 0, 0, 0, 64, FMT_YUV420, 32'h1000, 0, 0, 0), 1, hidden_regs(0));
        add_row(place(1, 4095, 4095, 4095, 4095, FMT_ARGB454, '1, '1, '1, 4095),
                1, hidden_regs(1));
        add_row(place(2, -4096, -4096, 4095, 4095, FMT_ARGB888, '1, '1, '1, 4095),
                1, hidden_regs(2));
        add_row(place(0, 100, 201, 64, 5, FMT_RGB565, 32'h8000_0000, 0, 0, 64), 0, '0);
        add_row(place(1, -17, -3, 320, 240, FMT_YUV420, 32'hffff_fff0, 32'hffff_ff00,
                      32'hffff_f000, 4095), 0, '0);
        add_row(place(2, 33, -7, 640, 360, FMT_Y_UV420, 32'h1000_0000, 32'h2000_0000,
                      32'h3000_0000, 640), 0, '0);
        add_row(place(0, 5, -9, 4095, 100, FMT_RGB565, '1, 0, 0, 0), 0, '0);
        add_row(place(1, -1, -1, 100, 100, FMT_ARGB454, 32'h0000_0400, 0, 0, 100), 0, '0);
        add_row(place(2, -100, -50, 4095, 4095, FMT_ARGB888, 32'h4000_0000, 0, 0, 0), 0, '0);
        add_row(place(0, 3, 3, 720, 4095, FMT_YUV420, 32'h100, 32'h200, 32'h300, 720), 0, '0);
        add_row(place(1, 0, -4096, 720, 4095, FMT_Y_UV420, 32'h100, 32'h200, 0, 4095), 0, '0);
        add_row(place(2, -20, 10, 20, 50, FMT_RGB565, 32'h5000, 0, 0, 20), 0, '0);
        add_row(place(1, 790, 470, 100, 100, FMT_RGB565, 32'h6000, 0, 0, 100), 0, '0);
        add_row(place(2, 4095, -1, 200, 200, FMT_ARGB888, 32'h7000, 0, 0, 200), 0, '0);
        add_row(place(0, -4095, -4095, 4095, 4095, FMT_YUV420, '1, '1, '1, 4095), 0, '0);
        add_row(place(1, 16, 1, 320, 480, FMT_YUV420, 32'h9000, 32'ha000, 32'hb000, 320),
                0, '0);
        add_row(place(2, 0, 0, 4095, 4095, FMT_ARGB888, 32'hc000, 0, 0, 0), 0, '0);

        phase_w = '{4095, 1, 16, 0, 1920, 800};
        phase_h = '{4095, 1, 6, 0, 1080, 480};
        phase_n = '{180, 60, 120, 40, 180, 170};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[i]) begin
            send_placement(dir_table[i].pl, 0,
                           dir_table[i].typed ? dir_table[i].want
                                              : clip_layer(dir_table[i].pl, scr_w, scr_h));
        end
        drain_pipe();

        for (int ph = 0; ph < 6; ph++) begin
            write_screen(phase_w[ph][11:0], phase_h[ph][11:0]);
            case (ph % 3)
                0: idle_pct = 16;
                1: idle_pct = 72;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < phase_n[ph]; n++) begin
                if ($urandom_range(0, 99) == 0) drain_pipe();
                p = rand_placement(phase_w[ph], phase_h[ph]);
                send_placement(p, idle_pct, clip_layer(p, scr_w, scr_h));
            end
            drain_pipe();
        end

        repeat (PIPE_LAT + 8) @(posedge i_clk);
        if (expected_layer_regs.size() != 0)
            report_mismatch("results never returned", expected_layer_regs.size(), 0);

        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
